@@ rtl/core/flac_mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata parser package
// Shared types and constants for the byte parser, request queue and result
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

package flac_mbp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_PAYLOAD,
    PH_IDLE
  } phase_t;

  // Result kinds as seen on the output
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_INFO      = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  // Result stage state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FINISH
  } back_state_t;

  localparam int unsigned RATE_W     = 20;
  localparam int unsigned SAMPLES_W  = 36;
  localparam int unsigned DIVIDEND_W = 46;   // samples * 1000 fits in 46 bits

  localparam logic [31:0] MAGIC_WORD     = 32'h664C6143;  // "fLaC"
  localparam logic [4:0]  HDR_LAST_IDX   = 5'd3;
  localparam logic [4:0]  INFO_FIRST_POS = 5'd10;
  localparam logic [4:0]  INFO_LAST_POS  = 5'd17;
  localparam logic [4:0]  POS_MAX        = 5'd31;
  localparam logic [23:0] INFO_SPAN      = 24'd17;
  localparam logic [31:0] INFO_BACKUP    = 32'd17;
  localparam logic [6:0]  TYPE_STREAMINFO = 7'd0;
  localparam logic [5:0]  DIV_STEPS      = 6'd46;
  localparam logic [31:0] DUR_MAX        = 32'hFFFF_FFFF;

  // One request from the parser to the result stage
  typedef struct packed {
    kind_t                kind;
    logic [6:0]           block_type;
    logic [23:0]          block_size;
    logic [31:0]          data_offset;
    logic                 last_block;
    logic [RATE_W-1:0]    srate;
    logic [3:0]           channel_count;
    logic [SAMPLES_W-1:0] samples;
    logic                 walk_done;
  } req_t;

endpackage

`default_nettype wire

@@ rtl/core/flac_metadata_block_parser.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata block parser (top level)
// Byte-wise FLAC metadata walker with header reporting and stream info decode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one file byte per request, with
//   in_first_byte marking offset 0 and restarting the walk. The parser takes
//   one byte per cycle; it stalls only when its request queue is full.
//   Output channel (out_valid / out_stall): one result per request: block
//   header, decoded stream info, or bad magic.
//   Result path: header and bad magic results pass through the queue and the
//   output register. Stream info results first run the 46-step
//   one-bit-per-cycle duration divide in the result stage; header
//   results behind it wait in the queue, so order is kept.
//   Throughput: 1 byte per cycle sustained; the queue fills and the input
//   stalls only when several headers pile up behind a running divide or the
//   receiver stalls for a while.
//   Reset: synchronous active-low rst_n; the parser expects the magic on the
//   next byte and the queue and output register are emptied.
//   Receiver stall: the output register holds its result; the queue absorbs
//   new requests and the input stalls once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_metadata_block_parser
  import flac_mbp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64,  // walk stops after this many blocks
  parameter int unsigned FIFO_DEPTH = 4    // parser to result stage queue
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_first_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [6:0]       out_block_type,
  output logic [23:0]      out_block_size,
  output logic [31:0]      out_data_offset,
  output logic             out_last_block,
  output logic [19:0]      out_srate,
  output logic [3:0]       out_channel_count,
  output logic [31:0]      out_length_msec,
  output logic             out_walk_done
);

  logic in_accept;
  logic push;
  req_t push_req;
  logic pop;
  req_t head;
  logic q_empty;
  logic q_full;

  // Stall on a full queue; the parser itself takes every byte it is offered.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: magic, header and payload walk
  flac_mbp_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .byte_value (in_byte_value),
    .first_byte (in_first_byte),
    .push       (push),
    .req        (push_req)
  );

  // Queue lets the parser run on while a divide is in flight
  flac_mbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_req),
    .pop     (pop),
    .rd_data (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Back: duration divide and output register
  flac_mbp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .fifo_empty         (q_empty),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_block_type     (out_block_type),
    .out_block_size     (out_block_size),
    .out_data_offset    (out_data_offset),
    .out_last_block     (out_last_block),
    .out_srate          (out_srate),
    .out_channel_count  (out_channel_count),
    .out_length_msec    (out_length_msec),
    .out_walk_done      (out_walk_done)
  );

endmodule

`default_nettype wire

@@ rtl/core/flac_mbp_front.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata byte parser
// Walks magic, block headers and payloads one byte per accepted request and
// issues header / stream info / bad magic requests.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_mbp_front
  import flac_mbp_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] byte_value,
  input  wire logic       first_byte,
  output logic            push,
  output req_t            req
);

  localparam logic [6:0] MAX_B = 7'(MAX_BLOCKS);

  phase_t      phase_r, phase_nxt, ph_c;
  logic [4:0]  idx_r, idx_nxt, idx_c;
  logic [31:0] hs_r, hs_nxt, hs_c;
  logic [23:0] rem_r, rem_nxt, rem_c;
  logic [6:0]  type_r, type_nxt, type_c;
  logic        last_r, last_nxt, last_c;
  logic [6:0]  blocks_r, blocks_nxt, blocks_c;
  logic [63:0] info_r, info_nxt, info_c;
  logic [31:0] off_r, off_nxt, off_c;

  logic [31:0] shift_w;
  logic [63:0] info_w;
  logic [6:0]  blocks_inc;
  logic        walk_c;
  logic        walk_h;
  logic [23:0] rem_dec;
  logic        emit;

  always_comb begin
    // first_byte restarts everything before this byte is used
    ph_c     = phase_r;
    idx_c    = idx_r;
    hs_c     = hs_r;
    rem_c    = rem_r;
    type_c   = type_r;
    last_c   = last_r;
    blocks_c = blocks_r;
    info_c   = info_r;
    off_c    = off_r;
    if (first_byte) begin
      ph_c     = PH_MAGIC;
      idx_c    = '0;
      hs_c     = '0;
      rem_c    = '0;
      type_c   = '0;
      last_c   = 1'b0;
      blocks_c = '0;
      info_c   = '0;
      off_c    = '0;
    end

    phase_nxt  = ph_c;
    idx_nxt    = idx_c;
    hs_nxt     = hs_c;
    rem_nxt    = rem_c;
    type_nxt   = type_c;
    last_nxt   = last_c;
    blocks_nxt = blocks_c;
    info_nxt   = info_c;
    off_nxt    = off_c + 32'd1;

    shift_w    = {hs_c[23:0], byte_value};
    info_w     = {info_c[55:0], byte_value};
    blocks_inc = blocks_c + 7'd1;
    walk_c     = last_c || (blocks_c >= MAX_B);
    walk_h     = shift_w[31] || (blocks_inc >= MAX_B);
    rem_dec    = rem_c - 24'd1;
    emit       = 1'b0;
    req        = '0;

    unique case (ph_c)
      PH_MAGIC: begin
        hs_nxt  = shift_w;
        idx_nxt = idx_c + 5'd1;
        if (idx_c >= HDR_LAST_IDX) begin
          idx_nxt = '0;
          if (shift_w == MAGIC_WORD) begin
            phase_nxt = PH_HEADER;
            hs_nxt    = '0;
          end else begin
            phase_nxt     = PH_IDLE;
            type_nxt      = '0;
            last_nxt      = 1'b0;
            emit          = 1'b1;
            req.kind      = KIND_BAD_MAGIC;
            req.walk_done = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        hs_nxt  = shift_w;
        idx_nxt = idx_c + 5'd1;
        if (idx_c >= HDR_LAST_IDX) begin
          last_nxt   = shift_w[31];
          type_nxt   = shift_w[30:24];
          blocks_nxt = blocks_inc;
          idx_nxt    = '0;
          hs_nxt     = '0;
          info_nxt   = '0;
          emit               = 1'b1;
          req.kind           = KIND_HEADER;
          req.block_type     = shift_w[30:24];
          req.block_size     = shift_w[23:0];
          req.data_offset    = off_c + 32'd1;
          req.last_block     = shift_w[31];
          req.walk_done      = walk_h;
          if (shift_w[23:0] == 24'd0) begin
            phase_nxt = walk_h ? PH_IDLE : PH_HEADER;
          end else begin
            phase_nxt = PH_PAYLOAD;
            rem_nxt   = shift_w[23:0];
          end
        end
      end
      PH_PAYLOAD: begin
        if (type_c == TYPE_STREAMINFO && idx_c >= INFO_FIRST_POS &&
            idx_c <= INFO_LAST_POS) begin
          info_nxt = info_w;
        end
        // rate of zero: stream info is dropped
        if (type_c == TYPE_STREAMINFO && idx_c == INFO_LAST_POS &&
            info_w[63:44] != '0) begin
          emit               = 1'b1;
          req.kind           = KIND_INFO;
          req.block_type     = type_c;
          req.block_size     = rem_c + INFO_SPAN;
          req.data_offset    = off_c - INFO_BACKUP;
          req.last_block     = last_c;
          req.srate          = info_w[63:44];
          req.channel_count  = {1'b0, info_w[43:41]} + 4'd1;
          req.samples        = info_w[SAMPLES_W-1:0];
          req.walk_done      = walk_c;
        end
        if (idx_c < POS_MAX) begin
          idx_nxt = idx_c + 5'd1;
        end
        rem_nxt = rem_dec;
        if (rem_dec == 24'd0) begin
          idx_nxt   = '0;
          phase_nxt = walk_c ? PH_IDLE : PH_HEADER;
        end
      end
      PH_IDLE: begin
      end
    endcase

    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      idx_r    <= '0;
      hs_r     <= '0;
      rem_r    <= '0;
      type_r   <= '0;
      last_r   <= 1'b0;
      blocks_r <= '0;
      info_r   <= '0;
      off_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      hs_r     <= hs_nxt;
      rem_r    <= rem_nxt;
      type_r   <= type_nxt;
      last_r   <= last_nxt;
      blocks_r <= blocks_nxt;
      info_r   <= info_nxt;
      off_r    <= off_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/flac_mbp_fifo.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata request queue
// Small register queue between the byte parser and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_mbp_fifo
  import flac_mbp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      wr_data,
  input  wire logic pop,
  output req_t      rd_data,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  req_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == DEPTH_C);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/core/flac_mbp_back.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata result stage
// Drains the request queue into the output register; stream info requests
// first run a one-bit-per-cycle duration divide.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_mbp_back
  import flac_mbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  req_t                    head,
  input  wire logic               fifo_empty,
  output logic                    pop,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [1:0]              out_result_kind,
  output logic [6:0]              out_block_type,
  output logic [23:0]             out_block_size,
  output logic [31:0]             out_data_offset,
  output logic                    out_last_block,
  output logic [RATE_W-1:0]       out_srate,
  output logic [3:0]              out_channel_count,
  output logic [31:0]             out_length_msec,
  output logic                    out_walk_done
);

  back_state_t           state_r, state_nxt;
  req_t                  hold_r, hold_nxt;
  logic [RATE_W-1:0]     rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [5:0]            step_r, step_nxt;

  logic        ov_r, ov_nxt;
  req_t        ores_r, ores_nxt;
  logic [31:0] dur_r, dur_nxt;

  logic                  out_free;
  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;
  logic                  fits;
  logic [DIVIDEND_W-1:0] samples_ext;
  logic [DIVIDEND_W-1:0] dividend;

  always_comb begin
    out_free = !ov_r || !out_stall;

    // samples * 1000 = samples * (1024 - 16 - 8)
    samples_ext = DIVIDEND_W'(head.samples);
    dividend    = (samples_ext << 10) - (samples_ext << 4) - (samples_ext << 3);

    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, hold_r.srate};
    diff  = trial - {1'b0, hold_r.srate};

    state_nxt = state_r;
    hold_nxt  = hold_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    ores_nxt  = ores_r;
    dur_nxt   = dur_r;
    ov_nxt    = ov_r && out_stall;
    pop       = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          if (head.kind == KIND_INFO) begin
            pop       = 1'b1;
            hold_nxt  = head;
            rem_nxt   = '0;
            quo_nxt   = dividend;
            step_nxt  = '0;
            state_nxt = BK_DIV;
          end else if (out_free) begin
            pop      = 1'b1;
            ores_nxt = head;
            dur_nxt  = '0;
            ov_nxt   = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_nxt  = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
        step_nxt = step_r + 6'd1;
        if (step_r == DIV_STEPS - 6'd1) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          ores_nxt  = hold_r;
          dur_nxt   = (quo_r[DIVIDEND_W-1:32] != '0) ? DUR_MAX : quo_r[31:0];
          ov_nxt    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    ores_r <= ores_nxt;
    dur_r  <= dur_nxt;
  end

  assign out_valid          = ov_r;
  assign out_result_kind    = ores_r.kind;
  assign out_block_type     = ores_r.block_type;
  assign out_block_size     = ores_r.block_size;
  assign out_data_offset    = ores_r.data_offset;
  assign out_last_block     = ores_r.last_block;
  assign out_srate          = ores_r.srate;
  assign out_channel_count  = ores_r.channel_count;
  assign out_length_msec    = dur_r;
  assign out_walk_done      = ores_r.walk_done;

  a_div_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |->
      (hold_r.kind == KIND_INFO && hold_r.srate != '0))
    else $error("divide running without a stream info request");

  a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (rem_r < hold_r.srate))
    else $error("partial remainder not below divisor");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !pop)
    else $error("queue popped while divide in progress");

endmodule

`default_nettype wire

@@ tb/flac_metadata_block_parser_tb.sv @@
// ----------------------------------------------------------------------------
// FLAC metadata block parser testbench
// Streams FLAC files into the parser one byte per request and checks every
// result against a predictor of the metadata walk. The directed part covers
// bad magic, a last STREAMINFO block and saturated duration. The random part
// sends well-formed files with random content, plus truncated files, bad
// magic, short files, 64-block walks and byte noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module flac_metadata_block_parser_tb
  import flac_mbp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WALK_LIMIT   = 64;     // blocks before the walk stops
  localparam int          RANDOM_BYTES = 1350;   // non-ignored bytes in the random part
  localparam int          IDLE_LIMIT   = 5000;   // cycles with no request before timeout
  localparam int          DRAIN_CYCLES = 200;    // covers the stream info divide and stalls
  localparam int          REPORT_CAP   = 50;     // keep the log short on a broken build
  localparam logic [31:0] FLAC_MAGIC   = "fLaC";

  // One result as it appears on the out_ ports
  typedef struct packed {
    kind_t       kind;
    logic [6:0]  btype;
    logic [23:0] bsize;
    logic [31:0] poff;
    logic        last;
    logic [19:0] rate;
    logic [3:0]  chans;
    logic [31:0] dur;
    logic        done;
  } walk_result_t;

  // Directed row: a byte, its first flag, and optionally a result typed in
  typedef struct packed {
    logic [7:0]   value;
    logic         first;
    logic         pinned;
    walk_result_t res;
  } dir_row_t;

  localparam walk_result_t NO_RESULT =
    '{KIND_HEADER, 7'd0, 24'd0, 32'd0, 1'b0, 20'd0, 4'd0, 32'd0, 1'b0};
  localparam walk_result_t BAD_MAGIC_RES =
    '{KIND_BAD_MAGIC, 7'd0, 24'd0, 32'd0, 1'b0, 20'd0, 4'd0, 32'd0, 1'b1};
  // Last STREAMINFO header, 18 bytes, payload right after the magic and header
  localparam walk_result_t INFO_HDR_RES =
    '{KIND_HEADER, 7'd0, 24'd18, 32'd8, 1'b1, 20'd0, 4'd0, 32'd0, 1'b1};
  // Rate 1, 8 channels, all-ones sample count: duration saturates
  localparam walk_result_t INFO_SAT_RES =
    '{KIND_INFO, 7'd0, 24'd18, 32'd8, 1'b1, 20'd1, 4'd8, 32'hFFFF_FFFF, 1'b1};

  localparam int DIR_ROWS = 30;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // no first flag after reset: magic expected anyway, "XLaC" is bad
    '{8'h58, 1'b0, 1'b0, NO_RESULT},
    '{8'h4C, 1'b0, 1'b0, NO_RESULT},
    '{8'h61, 1'b0, 1'b0, NO_RESULT},
    '{8'h43, 1'b0, 1'b1, BAD_MAGIC_RES},
    // restart with a good magic
    '{8'h66, 1'b1, 1'b0, NO_RESULT},
    '{8'h4C, 1'b0, 1'b0, NO_RESULT},
    '{8'h61, 1'b0, 1'b0, NO_RESULT},
    '{8'h43, 1'b0, 1'b0, NO_RESULT},
    // header: last flag, type 0, size 18
    '{8'h80, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, 1'b1, INFO_HDR_RES},
    // block sizes, frame sizes: don't care, extremes of the byte
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    // rate 1, channels-1 = 7, bps all ones, samples all ones
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h1F, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b1, INFO_SAT_RES}
  };

  // DUT ports, inputs known from time zero
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  out_result_kind;
  logic [6:0]  out_block_type;
  logic [23:0] out_block_size;
  logic [31:0] out_data_offset;
  logic        out_last_block;
  logic [19:0] out_srate;
  logic [3:0]  out_channel_count;
  logic [31:0] out_length_msec;
  logic        out_walk_done;

  flac_metadata_block_parser #(
    .MAX_BLOCKS(WALK_LIMIT)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_block_type    (out_block_type),
    .out_block_size    (out_block_size),
    .out_data_offset   (out_data_offset),
    .out_last_block    (out_last_block),
    .out_srate         (out_srate),
    .out_channel_count (out_channel_count),
    .out_length_msec   (out_length_msec),
    .out_walk_done     (out_walk_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Walk predictor state
  // --------------------------------------------------------------------------
  phase_t      pw_phase;
  logic [4:0]  pw_pos;      // byte index in magic, header or payload
  logic [31:0] pw_hdr;      // magic / header shift register
  logic [23:0] pw_left;     // payload bytes still to come
  logic [6:0]  pw_type;
  logic        pw_last;
  logic [6:0]  pw_count;    // headers parsed in this file
  logic [63:0] pw_info;     // STREAMINFO bytes 10..17
  logic [31:0] pw_offset;   // file offset of the next byte

  walk_result_t pending_results[$];
  logic [7:0]   file_bytes[$];
  int           mismatches  = 0;
  int           bytes_taken = 0;
  int           idle_cycles = 0;
  int           stall_left  = 0;
  bit           calm        = 1'b0;  // no idling on either side while set

  function automatic void restart_walk();
    pw_phase  = PH_MAGIC;
    pw_pos    = '0;
    pw_hdr    = '0;
    pw_left   = '0;
    pw_type   = '0;
    pw_last   = 1'b0;
    pw_count  = '0;
    pw_info   = '0;
    pw_offset = '0;
  endfunction

  function automatic bit walk_over();
    return pw_last || (pw_count >= WALK_LIMIT);
  endfunction

  // Advance the walk by one byte; got is set when the byte completes a result,
  // used is clear when the byte is ignored (walk already finished).
  task automatic predict_walk(input logic [7:0] b, input logic first,
                              output bit got, output walk_result_t r, output bit used);
    logic [31:0] here;
    logic [23:0] sz;
    logic [19:0] rate;
    logic [63:0] dividend;
    logic [63:0] quot;
    got = 1'b0;
    r   = NO_RESULT;
    if (first) restart_walk();
    used      = (pw_phase != PH_IDLE);
    here      = pw_offset;
    pw_offset = pw_offset + 32'd1;
    case (pw_phase)
      PH_MAGIC: begin
        pw_hdr = {pw_hdr[23:0], b};
        pw_pos = pw_pos + 5'd1;
        if (pw_pos >= 5'd4) begin
          pw_pos = '0;
          if (pw_hdr == FLAC_MAGIC) begin
            pw_phase = PH_HEADER;
            pw_hdr   = '0;
          end else begin
            pw_phase = PH_IDLE;
            pw_type  = '0;
            pw_last  = 1'b0;
            r        = BAD_MAGIC_RES;
            got      = 1'b1;
          end
        end
      end
      PH_HEADER: begin
        pw_hdr = {pw_hdr[23:0], b};
        pw_pos = pw_pos + 5'd1;
        if (pw_pos >= 5'd4) begin
          sz       = pw_hdr[23:0];
          pw_last  = pw_hdr[31];
          pw_type  = pw_hdr[30:24];
          pw_count = pw_count + 7'd1;
          pw_pos   = '0;
          pw_hdr   = '0;
          pw_info  = '0;
          r.kind   = KIND_HEADER;
          r.btype  = pw_type;
          r.bsize  = sz;
          r.poff   = here + 32'd1;
          r.last   = pw_last;
          r.done   = walk_over();
          got      = 1'b1;
          if (sz == '0) begin
            pw_phase = walk_over() ? PH_IDLE : PH_HEADER;
          end else begin
            pw_phase = PH_PAYLOAD;
            pw_left  = sz;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pw_type == '0 && pw_pos >= 5'd10 && pw_pos <= 5'd17) begin
          pw_info = {pw_info[55:0], b};
        end
        if (pw_type == '0 && pw_pos == 5'd17) begin
          rate = pw_info[63:44];
          if (rate != '0) begin
            dividend = {28'd0, pw_info[35:0]} * 64'd1000;
            quot     = dividend / {44'd0, rate};
            if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
            r.kind  = KIND_INFO;
            r.btype = pw_type;
            r.bsize = pw_left + 24'd17;
            r.poff  = here - 32'd17;
            r.last  = pw_last;
            r.rate  = rate;
            r.chans = {1'b0, pw_info[43:41]} + 4'd1;
            r.dur   = quot[31:0];
            r.done  = walk_over();
            got     = 1'b1;
          end
        end
        if (pw_pos < 5'd31) pw_pos = pw_pos + 5'd1;
        pw_left = pw_left - 24'd1;
        if (pw_left == '0) begin
          pw_pos   = '0;
          pw_phase = walk_over() ? PH_IDLE : PH_HEADER;
        end
      end
      default: ;  // finished walk: byte ignored
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one byte request, hold it until taken, then predict its result.
  task automatic feed(input logic [7:0] v, input logic f, input logic pin,
                      input walk_result_t pin_res);
    int           gap;
    bit           got;
    bit           used;
    walk_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= v;
    in_first_byte <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_walk(v, f, got, r, used);
    // a pinned row carries the result typed into the directed rows
    if (pin) pending_results.push_back(pin_res);
    else if (got) pending_results.push_back(r);
    if (used) bytes_taken++;
  endtask

  // --------------------------------------------------------------------------
  // File builders: fill file_bytes
  // --------------------------------------------------------------------------
  task automatic push_magic();
    for (int i = 3; i >= 0; i--) file_bytes.push_back(FLAC_MAGIC[i*8 +: 8]);
  endtask

  task automatic push_header(input logic last, input logic [6:0] btype,
                             input logic [23:0] sz);
    file_bytes.push_back({last, btype});
    file_bytes.push_back(sz[23:16]);
    file_bytes.push_back(sz[15:8]);
    file_bytes.push_back(sz[7:0]);
  endtask

  // Payload; for type 0 the bytes at 10..17 carry a chosen rate / channel /
  // sample count so the parser sees zero rates and the divide tiny, odd and full-scale ones.
  task automatic push_payload(input logic [6:0] btype, input int n);
    logic [19:0] rate;
    logic [35:0] samples;
    logic [63:0] info;
    case ($urandom_range(0, 9))
      0:       rate = '0;
      1, 2:    rate = 20'($urandom_range(1, 10));
      3, 4:    rate = 20'($urandom);
      5:       rate = 20'hFFFFF;
      6:       rate = 20'd44100;
      7:       rate = 20'd48000;
      8:       rate = 20'd96000;
      default: rate = 20'd8000;
    endcase
    case ($urandom_range(0, 5))
      0:       samples = '0;
      1:       samples = '1;
      default: samples = {4'($urandom_range(0, 15)), 32'($urandom)};
    endcase
    info = {rate, 3'($urandom), 5'($urandom), samples};
    for (int pos = 0; pos < n; pos++) begin
      if (btype == '0 && pos >= 10 && pos <= 17) begin
        file_bytes.push_back(info[(17 - pos) * 8 +: 8]);
      end else begin
        file_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic build_stream_file();
    int          nblk;
    int          sz;
    int          r;
    int          keep;
    logic [6:0]  btype;
    bit          last;
    bit          big;
    push_magic();
    nblk = $urandom_range(1, 6);
    for (int i = 0; i < nblk; i++) begin
      big = 1'b0;
      // STREAMINFO usually leads, sometimes shows up later
      if ($urandom_range(0, 9) < ((i == 0) ? 7 : 2)) btype = '0;
      else if ($urandom_range(0, 3) == 0) btype = 7'($urandom);
      else btype = 7'($urandom_range(1, 6));
      last = (i == nblk - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
      if (btype == '0) begin
        sz = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : $urandom_range(18, 40);
      end else begin
        r = $urandom_range(0, 19);
        if (r < 3) sz = 0;
        else if (r < 17) sz = $urandom_range(1, 24);
        else if (r < 19) sz = $urandom_range(100, 300);
        else begin
          sz  = $urandom_range(1000, 24'hFFFFFF);
          big = 1'b1;
        end
      end
      push_header(last, btype, 24'(sz));
      if (big) begin
        // huge block: the file ends long before the payload does
        push_payload(btype, $urandom_range(1, 30));
        break;
      end
      push_payload(btype, sz);
      if (last) break;
    end
    // truncated file: cut anywhere, even inside a header
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    // bytes after the walk is over are ignored
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
    end
  endtask

  // Magic with one bit flipped, or four random bytes
  task automatic build_bad_magic();
    int idx;
    push_magic();
    if ($urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, 3);
      file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
    end else begin
      foreach (file_bytes[i]) file_bytes[i] = 8'($urandom);
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic build_short_file();
    int n;
    n = $urandom_range(1, 3);
    push_magic();
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  // More headers than the walk allows; most blocks empty
  task automatic build_long_walk();
    int sz;
    push_magic();
    for (int i = 0; i < WALK_LIMIT + 2; i++) begin
      sz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      push_header(1'b0, 7'($urandom), 24'(sz));
      push_payload(7'd1, sz);
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic send_file(input bit noisy);
    logic f;
    foreach (file_bytes[i]) begin
      // noise may raise first_byte anywhere
      f = (i == 0) || (noisy && $urandom_range(0, 9) == 0);
      feed(file_bytes[i], f, 1'b0, NO_RESULT);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
          $display("%0t: result with nothing pending, expected none actual kind %0h",
                   $time, out_result_kind);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind",   32'(want.kind),  32'(out_result_kind));
        check_field("block_type",    32'(want.btype), 32'(out_block_type));
        check_field("block_size",    32'(want.bsize), 32'(out_block_size));
        check_field("data_offset",   want.poff,       out_data_offset);
        check_field("last_block",    32'(want.last),  32'(out_last_block));
        check_field("srate",         32'(want.rate),  32'(out_srate));
        check_field("channel_count", 32'(want.chans), 32'(out_channel_count));
        check_field("length_msec",   want.dur,        out_length_msec);
        check_field("walk_done",     32'(want.done),  32'(out_walk_done));
      end
    end
  end

  // Receiver stalls: random runs, none while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int file_no;
    bit noisy;
    restart_walk();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, no idling so the typed offsets line up with the rows
    calm = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      feed(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].first,
           DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res);
    end

    // random files until enough bytes have been parsed
    bytes_taken = 0;
    file_no     = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      calm  = ($urandom_range(0, 5) == 0);
      noisy = 1'b0;
      file_bytes.delete();
      r = $urandom_range(0, 99);
      if (file_no % 12 == 4) build_long_walk();
      else if (r < 72) build_stream_file();
      else if (r < 82) build_bad_magic();
      else if (r < 88) build_short_file();
      else begin
        build_noise();
        noisy = 1'b1;
      end
      send_file(noisy);
      file_no++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain: the watchdog ends a run whose results never come
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
